>>> rtl/core/ddo_pkg.sv
// Shared widths, codes and constant tables for the differential drive odometry block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned POS_W     = 32;   // Q16.16 positions and coordinates
    localparam int unsigned HEADING_W = 16;   // binary angle of a full turn
    localparam int unsigned CFG_W     = 32;   // configuration register width

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 3;   // two 32-bit registers at 0x0 and 0x4
    localparam int unsigned REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_TRAVEL_PER_REV = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEADING_GAIN   = 1'b1;

    // Item action codes.
    localparam logic ACTION_UPDATE = 1'b0;
    localparam logic ACTION_SET    = 1'b1;

    // Heading constants.
    localparam logic [HEADING_W-1:0] QUARTER_TURN = 16'h4000;

    // Sine and cosine unit.
    localparam int unsigned ANGLE_BITS_DEF = 16;
    localparam int unsigned PHASE_W        = 32;   // phase in 2^-32 turn units
    localparam int unsigned CORDIC_W       = 33;   // Q2.30 plus headroom
    localparam int unsigned ATAN_IDX_W     = 5;
    localparam int unsigned ATAN_W         = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 33'sd652032874;

    // Serial shift-and-add multiplier: 33-bit multiplier by 32-bit multiplicand.
    localparam int unsigned MUL_A_W   = 33;
    localparam int unsigned MUL_B_W   = 32;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_STEPS = MUL_A_W;
    localparam int unsigned STEP_W    = $clog2(MUL_STEPS);

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10679838;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41722;
            5'd15:   val = 30'd20861;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2608;
            5'd19:   val = 30'd1304;
            5'd20:   val = 30'd652;
            5'd21:   val = 30'd326;
            5'd22:   val = 30'd163;
            5'd23:   val = 30'd81;
            5'd24:   val = 30'd41;
            5'd25:   val = 30'd20;
            5'd26:   val = 30'd10;
            5'd27:   val = 30'd5;
            5'd28:   val = 30'd3;
            5'd29:   val = 30'd1;
            5'd30:   val = 30'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ddo_if.sv
// Valid/ready channel interfaces for the odometry block: command items in, pose results out.
// Depends on ddo_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ddo_cmd_if;
    import ddo_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        action;
    logic signed [POS_W-1:0]     left_position;
    logic signed [POS_W-1:0]     right_position;
    logic                        imu_present;
    logic        [HEADING_W-1:0] imu_heading;
    logic signed [POS_W-1:0]     new_x;
    logic signed [POS_W-1:0]     new_y;
    logic        [HEADING_W-1:0] new_heading;

    modport source (
        output valid, action, left_position, right_position, imu_present,
               imu_heading, new_x, new_y, new_heading,
        input  ready
    );

    modport sink (
        input  valid, action, left_position, right_position, imu_present,
               imu_heading, new_x, new_y, new_heading,
        output ready
    );
endinterface

interface ddo_pose_if;
    import ddo_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [POS_W-1:0]     pos_x_out;
    logic signed [POS_W-1:0]     pos_y_out;
    logic        [HEADING_W-1:0] heading_out;

    modport source (
        output valid, pos_x_out, pos_y_out, heading_out,
        input  ready
    );

    modport sink (
        input  valid, pos_x_out, pos_y_out, heading_out,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/differential_drive_odometry.sv
// Top level of the differential drive odometry block: APB registers, sequencer,
// serial multiplier and iterative sine/cosine. Depends on ddo_pkg and ddo_if.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// -----
// Command transactions arrive on cmd (valid/ready). An update transaction carries absolute
// wheel positions and an optional inertial heading; a set transaction rewrites the pose.
// Each command produces exactly one pose transaction on the pose channel, in order.
// The two gains (travel per revolution, heading per revolution) are written through the
// APB port at byte addresses 0x0 and 0x4; the user must do so only while the block is idle,
// which the block itself leaves unchecked. pready is always high.
//
// cmd.ready is high only while the sequencer is idle. A set transaction goes straight from
// idle to the write state. An update that derives heading from the wheels runs one more
// multiply than an update with an inertial heading, and the first update after reset skips
// the travel multiply. The length of an update is set by the one bit-serial multiplier,
// which retires one multiplier bit per cycle and is used up to four times per update, and
// by the rotation unit, which runs one iteration per cycle.
//
// The pose result sits in an output register, so the next command is taken while the last
// result still waits for pose.ready. If the receiver stalls longer than a whole update, the
// sequencer holds its finished result until the output register frees up.
//
// Reset (rst_n, asynchronous, active low) clears the pose, the heading offset, the latched
// wheel positions and both gains. The first update after reset only latches wheel positions
// and moves nothing, but it still sets the heading.
module differential_drive_odometry #(
    parameter int unsigned ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ddo_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ddo_pkg::CFG_W-1:0]       pwdata,
    output      logic [ddo_pkg::CFG_W-1:0]       prdata,
    output      logic                            pready,
    ddo_cmd_if.sink                              cmd,
    ddo_pose_if.source                           pose
);
    import ddo_pkg::*;

    // Iteration counter of the rotation unit.
    localparam int unsigned ITER_W = $clog2(ANGLE_BITS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ANGLE_BITS - 1);

    // The phase keeps only its top ANGLE_BITS bits.
    localparam logic [PHASE_W-1:0] PHASE_MASK = ~({PHASE_W{1'b1}} >> ANGLE_BITS);

    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(MUL_STEPS - 1);
    localparam logic [MUL_P_W-1:0] TRAV_HALF = MUL_P_W'(65536);
    localparam logic [63:0]        ROT_HALF  = 64'd536870912;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_MUL,
        S_HEAD_FIN,
        S_TRAV_SUM,
        S_TRAV_ABS,
        S_TRAV_MUL,
        S_TRAV_FIN,
        S_ROT_INIT,
        S_ROT_ITER,
        S_ROT_QUAD,
        S_X_MUL,
        S_X_FIN,
        S_Y_MUL,
        S_Y_FIN,
        S_POS_ADD,
        S_WRITE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [CFG_W-1:0] travel_reg;
    logic [CFG_W-1:0] gain_reg;

    // Architectural pose state.
    logic [POS_W-1:0]     pos_x_reg;
    logic [POS_W-1:0]     pos_y_reg;
    logic [HEADING_W-1:0] heading_reg;
    logic [HEADING_W-1:0] offset_reg;
    logic [POS_W-1:0]     last_left_reg;
    logic [POS_W-1:0]     last_right_reg;
    logic                 have_last_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [POS_W-1:0]     out_x_reg;
    logic [POS_W-1:0]     out_y_reg;
    logic [HEADING_W-1:0] out_heading_reg;

    // Working registers of one update.
    logic [POS_W-1:0]     dl_reg;
    logic [POS_W-1:0]     dr_reg;
    logic                 moving_reg;
    logic [POS_W:0]       sum_reg;
    logic [HEADING_W-1:0] ang_reg;
    logic [POS_W-1:0]     dist_mag_reg;
    logic                 dist_neg_reg;
    logic signed [CORDIC_W-1:0] cx_reg;
    logic signed [CORDIC_W-1:0] cy_reg;
    logic signed [PHASE_W-1:0]  cz_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [1:0]           quad_reg;
    logic [MUL_B_W-1:0]   sin_mag_reg;
    logic                 sin_neg_reg;
    logic [POS_W-1:0]     dx_reg;
    logic [POS_W-1:0]     dy_reg;

    // Bit-serial multiplier: the multiplier word shifts out of mul_lo_reg one bit a cycle
    // while the product's low half shifts in behind it.
    logic [MUL_B_W-1:0] mul_hi_reg;
    logic [MUL_A_W-1:0] mul_lo_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               prod_neg_reg;
    logic [MUL_B_W:0]   mul_sum;
    logic [MUL_B_W-1:0] mul_hi_next;
    logic [MUL_A_W-1:0] mul_lo_next;
    logic [MUL_P_W-1:0] mul_prod;
    logic               mul_run;

    logic cmd_fire;
    logic cfg_write;
    logic out_free;

    // Combinational helpers.
    logic [MUL_P_W-1:0]   trav_round;
    logic [47:0]          trav_units;
    logic                 trav_big;
    logic [63:0]          rot_round;
    logic [POS_W-1:0]     rot_delta;
    logic [PHASE_W-1:0]   phase;
    logic signed [CORDIC_W-1:0] cx_shift;
    logic signed [CORDIC_W-1:0] cy_shift;
    logic [PHASE_W-1:0]   atan_val;
    logic [CORDIC_W-1:0]  abs_x;
    logic [CORDIC_W-1:0]  abs_y;
    logic [POS_W:0]       sum_abs;
    logic [HEADING_W-1:0] enc_ang;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !out_valid_reg || pose.ready;

    assign cmd.ready        = (state_reg == S_IDLE);
    assign pose.valid       = out_valid_reg;
    assign pose.pos_x_out   = out_x_reg;
    assign pose.pos_y_out   = out_y_reg;
    assign pose.heading_out = out_heading_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEADING_GAIN) ? gain_reg : travel_reg;

    // One multiplier step.
    assign mul_run     = state_reg inside {S_HEAD_MUL, S_TRAV_MUL, S_X_MUL, S_Y_MUL};
    assign mul_sum     = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_b_reg} : '0);
    assign mul_hi_next = mul_sum[MUL_B_W:1];
    assign mul_lo_next = {mul_sum[0], mul_lo_reg[MUL_A_W-1:1]};
    assign mul_prod    = {mul_hi_reg, mul_lo_reg};

    // Heading from the wheel difference: the integer-turn bits of the product are dropped.
    assign enc_ang = mul_prod[31:16] + QUARTER_TURN + offset_reg;

    // Travel: round half a unit, drop 17 bits (the mean of the two wheels and Q16.16).
    assign trav_round = mul_prod + TRAV_HALF;
    assign trav_units = trav_round[MUL_P_W-1:17];
    assign trav_big   = |trav_units[47:31];

    // Signed product rounded to nearest and shifted down by 30 bits, floor semantics.
    assign rot_round = prod_neg_reg ? (ROT_HALF - mul_prod[63:0])
                                    : (mul_prod[63:0] + ROT_HALF);
    assign rot_delta = rot_round[61:30];

    assign sum_abs = sum_reg[POS_W] ? (~sum_reg + 1'b1) : sum_reg;

    // Rotation unit operands.
    assign phase    = {ang_reg, {(PHASE_W - HEADING_W){1'b0}}} & PHASE_MASK;
    assign cx_shift = cx_reg >>> iter_reg;
    assign cy_shift = cy_reg >>> iter_reg;
    assign atan_val = {{(PHASE_W - ATAN_W){1'b0}}, atan_turn(ATAN_IDX_W'(iter_reg))};
    assign abs_x    = cx_reg[CORDIC_W-1] ? (-cx_reg) : cx_reg;
    assign abs_y    = cy_reg[CORDIC_W-1] ? (-cy_reg) : cy_reg;

    // Sequencer, architectural state, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            travel_reg      <= '0;
            gain_reg        <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            heading_reg     <= '0;
            offset_reg      <= '0;
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            have_last_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_heading_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_TRAVEL_PER_REV: travel_reg <= pwdata;
                    REG_HEADING_GAIN:   gain_reg   <= pwdata;
                    default:            travel_reg <= travel_reg;
                endcase
            end

            // In S_WRITE the output register is reloaded below whenever it frees up.
            if (out_valid_reg && pose.ready && (state_reg != S_WRITE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        if (cmd.action == ACTION_SET)
                        begin
                            // Keep later headings continuous with the new heading.
                            offset_reg  <= cmd.new_heading - (heading_reg - offset_reg);
                            heading_reg <= cmd.new_heading;
                            pos_x_reg   <= cmd.new_x;
                            pos_y_reg   <= cmd.new_y;
                            state_reg   <= S_WRITE;
                        end
                        else
                        begin
                            last_left_reg  <= cmd.left_position;
                            last_right_reg <= cmd.right_position;
                            have_last_reg  <= 1'b1;
                            state_reg      <= cmd.imu_present ? S_TRAV_SUM : S_HEAD_MUL;
                        end
                    end
                end
                S_HEAD_MUL:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_HEAD_FIN;
                    end
                end
                S_HEAD_FIN:
                begin
                    state_reg <= S_TRAV_SUM;
                end
                S_TRAV_SUM:
                begin
                    state_reg <= moving_reg ? S_TRAV_ABS : S_ROT_INIT;
                end
                S_TRAV_ABS:
                begin
                    state_reg <= S_TRAV_MUL;
                end
                S_TRAV_MUL:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_TRAV_FIN;
                    end
                end
                S_TRAV_FIN:
                begin
                    state_reg <= S_ROT_INIT;
                end
                S_ROT_INIT:
                begin
                    heading_reg <= ang_reg;
                    state_reg   <= S_ROT_ITER;
                end
                S_ROT_ITER:
                begin
                    if (iter_reg == ITER_LAST)
                    begin
                        state_reg <= S_ROT_QUAD;
                    end
                end
                S_ROT_QUAD:
                begin
                    state_reg <= S_X_MUL;
                end
                S_X_MUL:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_X_FIN;
                    end
                end
                S_X_FIN:
                begin
                    state_reg <= S_Y_MUL;
                end
                S_Y_MUL:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_Y_FIN;
                    end
                end
                S_Y_FIN:
                begin
                    state_reg <= S_POS_ADD;
                end
                S_POS_ADD:
                begin
                    pos_x_reg <= pos_x_reg + dx_reg;
                    pos_y_reg <= pos_y_reg + dy_reg;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    // Hand the pose to the output register once it is free.
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_x_reg       <= pos_x_reg;
                        out_y_reg       <= pos_y_reg;
                        out_heading_reg <= heading_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath of one update: multiplier, travel and rotation registers.
    always_ff @(posedge clk)
    begin
        if (mul_run)
        begin
            mul_hi_reg <= mul_hi_next;
            mul_lo_reg <= mul_lo_next;
            step_reg   <= step_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    // Wheel deltas wrap as signed 32-bit values.
                    dl_reg       <= cmd.left_position - last_left_reg;
                    dr_reg       <= cmd.right_position - last_right_reg;
                    moving_reg   <= have_last_reg;
                    ang_reg      <= QUARTER_TURN - cmd.imu_heading + offset_reg;
                    mul_hi_reg   <= '0;
                    mul_lo_reg   <= {1'b0, cmd.right_position - cmd.left_position};
                    mul_b_reg    <= gain_reg;
                    step_reg     <= '0;
                end
            end
            S_HEAD_FIN:
            begin
                ang_reg <= enc_ang;
            end
            S_TRAV_SUM:
            begin
                sum_reg      <= {dl_reg[POS_W-1], dl_reg} + {dr_reg[POS_W-1], dr_reg};
                dist_mag_reg <= '0;
                dist_neg_reg <= 1'b0;
            end
            S_TRAV_ABS:
            begin
                mul_hi_reg   <= '0;
                mul_lo_reg   <= sum_abs;
                mul_b_reg    <= travel_reg;
                step_reg     <= '0;
                dist_neg_reg <= sum_reg[POS_W];
            end
            S_TRAV_FIN:
            begin
                // Saturate to the signed 32-bit range.
                if (trav_big)
                begin
                    dist_mag_reg <= dist_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    dist_mag_reg <= trav_units[POS_W-1:0];
                end
            end
            S_ROT_INIT:
            begin
                quad_reg <= phase[PHASE_W-1 -: 2];
                cz_reg   <= {2'b00, phase[PHASE_W-3:0]};
                cx_reg   <= CORDIC_K;
                cy_reg   <= '0;
                iter_reg <= '0;
            end
            S_ROT_ITER:
            begin
                if (!cz_reg[PHASE_W-1])
                begin
                    cx_reg <= cx_reg - cy_shift;
                    cy_reg <= cy_reg + cx_shift;
                    cz_reg <= cz_reg - atan_val;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_shift;
                    cy_reg <= cy_reg - cx_shift;
                    cz_reg <= cz_reg + atan_val;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            S_ROT_QUAD:
            begin
                // Fold the quadrant into magnitudes and signs; the sign of a zero
                // magnitude never reaches the result.
                mul_hi_reg <= '0;
                mul_lo_reg <= {1'b0, dist_mag_reg};
                step_reg   <= '0;
                case (quad_reg)
                    2'd0:
                    begin
                        mul_b_reg    <= abs_x[MUL_B_W-1:0];
                        prod_neg_reg <= dist_neg_reg ^ cx_reg[CORDIC_W-1];
                        sin_mag_reg  <= abs_y[MUL_B_W-1:0];
                        sin_neg_reg  <= cy_reg[CORDIC_W-1];
                    end
                    2'd1:
                    begin
                        mul_b_reg    <= abs_y[MUL_B_W-1:0];
                        prod_neg_reg <= dist_neg_reg ^ !cy_reg[CORDIC_W-1];
                        sin_mag_reg  <= abs_x[MUL_B_W-1:0];
                        sin_neg_reg  <= cx_reg[CORDIC_W-1];
                    end
                    2'd2:
                    begin
                        mul_b_reg    <= abs_x[MUL_B_W-1:0];
                        prod_neg_reg <= dist_neg_reg ^ !cx_reg[CORDIC_W-1];
                        sin_mag_reg  <= abs_y[MUL_B_W-1:0];
                        sin_neg_reg  <= !cy_reg[CORDIC_W-1];
                    end
                    default:
                    begin
                        mul_b_reg    <= abs_y[MUL_B_W-1:0];
                        prod_neg_reg <= dist_neg_reg ^ cy_reg[CORDIC_W-1];
                        sin_mag_reg  <= abs_x[MUL_B_W-1:0];
                        sin_neg_reg  <= !cx_reg[CORDIC_W-1];
                    end
                endcase
            end
            S_X_FIN:
            begin
                dx_reg       <= rot_delta;
                mul_hi_reg   <= '0;
                mul_lo_reg   <= {1'b0, dist_mag_reg};
                mul_b_reg    <= sin_mag_reg;
                step_reg     <= '0;
                prod_neg_reg <= dist_neg_reg ^ sin_neg_reg;
            end
            S_Y_FIN:
            begin
                dy_reg <= rot_delta;
            end
            default:
            begin
                dy_reg <= dy_reg;
            end
        endcase
    end

endmodule

`default_nettype wire
